// ----- design/tsort_pkg.sv -----
`timescale 1ns / 1ps
package tsort_pkg;
	localparam int TAG_W = 32;
	localparam int FRONT_W = 16;
	localparam int POS_W = 4;
	localparam int DEG_W = 5;
	localparam int S_TDATA_W = 48;
	localparam int M_TDATA_W = 40;
	localparam int PC_W = 5;

	// datapath operation selected by the current control word
	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_CLEAR,
		OP_CNT_ADD,
		OP_SCAN_INIT,
		OP_SCAN,
		OP_BREAK,
		OP_DEC_RD,
		OP_DEC_APPLY,
		OP_FILL_INIT,
		OP_FILL,
		OP_EMIT_INIT,
		OP_EMIT_PUSH,
		OP_EMIT_NEXT,
		OP_FINISH
	} dp_op_t;

	// branch condition tested by the sequencer
	typedef enum logic [3:0] {
		COND_ALWAYS,
		COND_LOAD_LAST,
		COND_CNT_LAST,
		COND_SCAN_DONE,
		COND_FOUND,
		COND_NO_LEAST,
		COND_POS_LAST,
		COND_FILL_LAST,
		COND_OUT_FREE,
		COND_EMIT_LAST
	} cond_t;

	typedef struct packed {
		dp_op_t           op;
		cond_t            cond;
		logic [PC_W-1:0]  jump_true;
		logic [PC_W-1:0]  jump_false;
	} ctrl_word_t;

	typedef struct packed {
		logic load_last;
		logic cnt_last;
		logic scan_done;
		logic found;
		logic no_least;
		logic pos_last;
		logic fill_last;
		logic out_free;
		logic emit_last;
	} status_t;

	typedef struct packed {
		logic [TAG_W-1:0] tag;
		logic [POS_W-1:0] position;
		logic             last;
		logic             cycle;
	} result_t;

	// program step addresses
	localparam logic [PC_W-1:0] ST_LOAD      = 5'd0;
	localparam logic [PC_W-1:0] ST_CLEAR     = 5'd1;
	localparam logic [PC_W-1:0] ST_CNT_RD    = 5'd2;
	localparam logic [PC_W-1:0] ST_CNT_ADD   = 5'd3;
	localparam logic [PC_W-1:0] ST_SCAN_INIT = 5'd4;
	localparam logic [PC_W-1:0] ST_SCAN      = 5'd5;
	localparam logic [PC_W-1:0] ST_SCAN_END  = 5'd6;
	localparam logic [PC_W-1:0] ST_BREAK     = 5'd7;
	localparam logic [PC_W-1:0] ST_DEC_RD    = 5'd8;
	localparam logic [PC_W-1:0] ST_DEC_APPLY = 5'd9;
	localparam logic [PC_W-1:0] ST_FILL_INIT = 5'd10;
	localparam logic [PC_W-1:0] ST_FILL      = 5'd11;
	localparam logic [PC_W-1:0] ST_EMIT_INIT = 5'd12;
	localparam logic [PC_W-1:0] ST_EMIT_ORD  = 5'd13;
	localparam logic [PC_W-1:0] ST_EMIT_TAG  = 5'd14;
	localparam logic [PC_W-1:0] ST_EMIT_PUSH = 5'd15;
	localparam logic [PC_W-1:0] ST_EMIT_NEXT = 5'd16;
	localparam logic [PC_W-1:0] ST_FINISH    = 5'd17;

	// control store
	function automatic ctrl_word_t ucode(input logic [PC_W-1:0] step);
		ctrl_word_t w;
		case (step)
			ST_LOAD:      w = '{OP_LOAD,      COND_LOAD_LAST, ST_CLEAR,     ST_LOAD};
			ST_CLEAR:     w = '{OP_CLEAR,     COND_ALWAYS,    ST_CNT_RD,    ST_CNT_RD};
			ST_CNT_RD:    w = '{OP_NONE,      COND_ALWAYS,    ST_CNT_ADD,   ST_CNT_ADD};
			ST_CNT_ADD:   w = '{OP_CNT_ADD,   COND_CNT_LAST,  ST_SCAN_INIT, ST_CNT_RD};
			ST_SCAN_INIT: w = '{OP_SCAN_INIT, COND_ALWAYS,    ST_SCAN,      ST_SCAN};
			ST_SCAN:      w = '{OP_SCAN,      COND_SCAN_DONE, ST_SCAN_END,  ST_SCAN};
			ST_SCAN_END:  w = '{OP_NONE,      COND_FOUND,     ST_DEC_RD,    ST_BREAK};
			ST_BREAK:     w = '{OP_BREAK,     COND_NO_LEAST,  ST_FILL_INIT, ST_DEC_RD};
			ST_DEC_RD:    w = '{OP_DEC_RD,    COND_ALWAYS,    ST_DEC_APPLY, ST_DEC_APPLY};
			ST_DEC_APPLY: w = '{OP_DEC_APPLY, COND_POS_LAST,  ST_EMIT_INIT, ST_SCAN_INIT};
			ST_FILL_INIT: w = '{OP_FILL_INIT, COND_ALWAYS,    ST_FILL,      ST_FILL};
			ST_FILL:      w = '{OP_FILL,      COND_FILL_LAST, ST_EMIT_INIT, ST_FILL};
			ST_EMIT_INIT: w = '{OP_EMIT_INIT, COND_ALWAYS,    ST_EMIT_ORD,  ST_EMIT_ORD};
			ST_EMIT_ORD:  w = '{OP_NONE,      COND_ALWAYS,    ST_EMIT_TAG,  ST_EMIT_TAG};
			ST_EMIT_TAG:  w = '{OP_NONE,      COND_ALWAYS,    ST_EMIT_PUSH, ST_EMIT_PUSH};
			ST_EMIT_PUSH: w = '{OP_EMIT_PUSH, COND_OUT_FREE,  ST_EMIT_NEXT, ST_EMIT_PUSH};
			ST_EMIT_NEXT: w = '{OP_EMIT_NEXT, COND_EMIT_LAST, ST_FINISH,    ST_EMIT_ORD};
			ST_FINISH:    w = '{OP_FINISH,    COND_ALWAYS,    ST_LOAD,      ST_LOAD};
			default:      w = '{OP_NONE,      COND_ALWAYS,    ST_LOAD,      ST_LOAD};
		endcase
		return w;
	endfunction
endpackage

// ----- design/tsort_ram.sv -----
`timescale 1ns / 1ps
module tsort_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ----- design/tsort_seq.sv -----
`timescale 1ns / 1ps
module tsort_seq (
	input  logic                clk,
	input  logic                arst_n,
	input  tsort_pkg::status_t  status,
	output tsort_pkg::dp_op_t   op
);
	import tsort_pkg::*;

	logic [PC_W-1:0] pc_q;
	ctrl_word_t      word;
	logic            take;

	assign word = ucode(pc_q);
	assign op   = word.op;

	always_comb begin
		case (word.cond)
			COND_ALWAYS:    take = 1'b1;
			COND_LOAD_LAST: take = status.load_last;
			COND_CNT_LAST:  take = status.cnt_last;
			COND_SCAN_DONE: take = status.scan_done;
			COND_FOUND:     take = status.found;
			COND_NO_LEAST:  take = status.no_least;
			COND_POS_LAST:  take = status.pos_last;
			COND_FILL_LAST: take = status.fill_last;
			COND_OUT_FREE:  take = status.out_free;
			COND_EMIT_LAST: take = status.emit_last;
			default:        take = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= ST_LOAD;
		end else begin
			pc_q <= take ? word.jump_true : word.jump_false;
		end
	end
endmodule

// ----- design/tsort_dp.sv -----
`timescale 1ns / 1ps
module tsort_dp #(
	parameter int MAX_NODES = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  tsort_pkg::dp_op_t              op,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [tsort_pkg::TAG_W-1:0]    in_tag,
	input  logic [tsort_pkg::FRONT_W-1:0]  in_front,
	input  logic                           in_last,
	input  logic                           out_free,
	output tsort_pkg::status_t             status,
	output logic                           push,
	output tsort_pkg::result_t             result
);
	import tsort_pkg::*;

	localparam int IDX_W   = $clog2(MAX_NODES);
	localparam int CNT_W   = $clog2(MAX_NODES + 1);
	localparam int DEG_N   = (MAX_NODES < FRONT_W) ? MAX_NODES : FRONT_W;
	localparam int DEG_IW  = $clog2(DEG_N);
	localparam int LEAST_W = (CNT_W > DEG_W) ? CNT_W : DEG_W;
	localparam logic [CNT_W-1:0] MAX_C   = CNT_W'(MAX_NODES);
	localparam logic [CNT_W-1:0] DEG_N_C = CNT_W'(DEG_N);

	logic [CNT_W-1:0]   count_q;
	logic [IDX_W-1:0]   i_q;
	logic [IDX_W-1:0]   k_q;
	logic [IDX_W-1:0]   pos_q;
	logic [IDX_W-1:0]   pick_q;
	logic [IDX_W-1:0]   least_at_q;
	logic [LEAST_W-1:0] least_q;
	logic               least_ok_q;
	logic               found_q;
	logic               cycle_q;
	logic [MAX_NODES-1:0] placed_q;
	logic [DEG_W-1:0]   deg_q [DEG_N];

	logic [CNT_W-1:0]   n_last;
	logic [DEG_N-1:0]   lane_live;
	logic [DEG_W-1:0]   d_k;
	logic               unplaced_k;
	logic               zero_hit;
	logic               less;
	logic               store_en;
	logic               emit_last;

	logic [TAG_W-1:0]   tag_rdata;
	logic [FRONT_W-1:0] front_rdata;
	logic [IDX_W-1:0]   ord_rdata;
	logic [IDX_W-1:0]   front_raddr;
	logic               ord_we;
	logic [IDX_W-1:0]   ord_wdata;

	assign n_last     = count_q - 1'b1;
	assign unplaced_k = !placed_q[k_q];
	assign d_k        = (CNT_W'(k_q) < DEG_N_C) ? deg_q[k_q[DEG_IW-1:0]] : '0;
	assign zero_hit   = unplaced_k && (d_k == '0);
	assign less       = unplaced_k && (d_k != '0) && (LEAST_W'(d_k) < least_q);
	assign store_en   = (op == OP_LOAD) && in_valid && (count_q < MAX_C);
	assign emit_last  = (CNT_W'(i_q) == n_last);

	always_comb begin
		for (int j = 0; j < DEG_N; j++) begin
			lane_live[j] = (CNT_W'(j) < count_q);
		end
	end

	// node stores and output order
	assign front_raddr = (op == OP_DEC_RD) ? pick_q : i_q;
	assign ord_we      = (op == OP_DEC_RD) || ((op == OP_FILL) && unplaced_k);
	assign ord_wdata   = (op == OP_DEC_RD) ? pick_q : k_q;

	tsort_ram #(.WIDTH(TAG_W), .DEPTH(MAX_NODES)) u_tag_ram (
		.clk   (clk),
		.we    (store_en),
		.waddr (count_q[IDX_W-1:0]),
		.wdata (in_tag),
		.raddr (ord_rdata),
		.rdata (tag_rdata)
	);

	tsort_ram #(.WIDTH(FRONT_W), .DEPTH(MAX_NODES)) u_front_ram (
		.clk   (clk),
		.we    (store_en),
		.waddr (count_q[IDX_W-1:0]),
		.wdata (in_front),
		.raddr (front_raddr),
		.rdata (front_rdata)
	);

	tsort_ram #(.WIDTH(IDX_W), .DEPTH(MAX_NODES)) u_order_ram (
		.clk   (clk),
		.we    (ord_we),
		.waddr (pos_q),
		.wdata (ord_wdata),
		.raddr (i_q),
		.rdata (ord_rdata)
	);

	// in-degree lanes, one per node that a front mask can name
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < DEG_N; j++) begin
				deg_q[j] <= '0;
			end
		end else begin
			for (int j = 0; j < DEG_N; j++) begin
				if (op == OP_CLEAR) begin
					deg_q[j] <= '0;
				end else if (op == OP_CNT_ADD && front_rdata[j] && lane_live[j]) begin
					deg_q[j] <= deg_q[j] + 1'b1;
				end else if (op == OP_DEC_APPLY && front_rdata[j] && lane_live[j]
						&& deg_q[j] != '0) begin
					deg_q[j] <= deg_q[j] - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			placed_q <= '0;
		end else if (op == OP_CLEAR) begin
			placed_q <= '0;
		end else if (op == OP_DEC_RD) begin
			placed_q[pick_q] <= 1'b1;
		end
	end

	// counters and flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			i_q        <= '0;
			k_q        <= '0;
			pos_q      <= '0;
			found_q    <= 1'b0;
			least_ok_q <= 1'b0;
			cycle_q    <= 1'b0;
		end else begin
			case (op)
				OP_LOAD: begin
					if (store_en) begin
						count_q <= count_q + 1'b1;
					end
				end
				OP_CLEAR: begin
					i_q     <= '0;
					pos_q   <= '0;
					cycle_q <= 1'b0;
				end
				OP_CNT_ADD: i_q <= i_q + 1'b1;
				OP_SCAN_INIT: begin
					k_q        <= '0;
					found_q    <= 1'b0;
					least_ok_q <= 1'b0;
				end
				OP_SCAN: begin
					k_q <= k_q + 1'b1;
					if (zero_hit) begin
						found_q <= 1'b1;
					end
					if (less) begin
						least_ok_q <= 1'b1;
					end
				end
				OP_BREAK: cycle_q <= 1'b1;
				OP_DEC_APPLY: pos_q <= pos_q + 1'b1;
				OP_FILL_INIT: k_q <= '0;
				OP_FILL: begin
					k_q <= k_q + 1'b1;
					if (unplaced_k) begin
						pos_q <= pos_q + 1'b1;
					end
				end
				OP_EMIT_INIT: i_q <= '0;
				OP_EMIT_NEXT: i_q <= i_q + 1'b1;
				OP_FINISH: begin
					count_q <= '0;
					cycle_q <= 1'b0;
				end
				default: ;
			endcase
		end
	end

	// scan candidates
	always_ff @(posedge clk) begin
		case (op)
			OP_SCAN_INIT: least_q <= LEAST_W'(count_q);
			OP_SCAN: begin
				if (zero_hit) begin
					pick_q <= k_q;
				end else if (less) begin
					least_q    <= LEAST_W'(d_k);
					least_at_q <= k_q;
				end
			end
			OP_BREAK: pick_q <= least_at_q;
			default: ;
		endcase
	end

	assign in_ready = (op == OP_LOAD);
	assign push     = (op == OP_EMIT_PUSH) && out_free;

	assign status.load_last = in_valid && in_last;
	assign status.cnt_last  = (CNT_W'(i_q) == n_last);
	assign status.scan_done = zero_hit || (CNT_W'(k_q) == n_last);
	assign status.found     = found_q;
	assign status.no_least  = !least_ok_q;
	assign status.pos_last  = (CNT_W'(pos_q) == n_last);
	assign status.fill_last = (CNT_W'(k_q) == n_last);
	assign status.out_free  = out_free;
	assign status.emit_last = emit_last;

	assign result.tag      = tag_rdata;
	assign result.position = POS_W'(i_q);
	assign result.last     = emit_last;
	assign result.cycle    = emit_last && cycle_q;
endmodule

// ----- design/topological_sort_cycle_break_top.sv -----
`timescale 1ns / 1ps
// topological sorter with cycle breaking
// input stream: one word per node, s_tdata = node tag and front mask, s_tlast marks
//   the last node of a set; words past MAX_NODES in one set are dropped
// output stream: one word per stored node, back to front, s_tlast-style m_tlast on
//   the final word and m_tuser set on that word when a cycle had to be broken
// loading: one node word per cycle while the block is taking input
// sorting: in-degree count adds in each node's front mask; each placement scans
//   for an unplaced node of zero in-degree, then applies its mask as decrements;
//   else breaks a cycle at the least in-degree node or fills the rest if none
// emission: each word takes two chained memory reads (order list then tag
//   store) that the microcode steps through, then a push and a next step
// s_tready is low from the last node word until the emit-next and finish steps
//   after the final result's push; the next set can load while that word still waits
// a stalled receiver holds the output register and the sequencer waits in its
//   emit step, nothing is lost
// after reset the stores are empty and the sequencer sits in its load step
module topological_sort_cycle_break_top #(
	parameter int MAX_NODES = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [tsort_pkg::S_TDATA_W-1:0]   s_tdata,   // node_tag, front_mask
	input  logic                              s_tlast,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [tsort_pkg::M_TDATA_W-1:0]   m_tdata,   // sorted_tag, sorted_position, pad
	output logic                              m_tuser,   // cycle_found
	output logic                              m_tlast
);
	import tsort_pkg::*;

	dp_op_t  op;
	status_t status;
	result_t result;
	result_t out_res_q;
	logic    out_valid_q;
	logic    out_free;
	logic    push;

	// output register is free when empty or being taken this cycle
	assign out_free = !out_valid_q || m_tready;

	tsort_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.status (status),
		.op     (op)
	);

	tsort_dp #(.MAX_NODES(MAX_NODES)) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.op       (op),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_tag   (s_tdata[TAG_W-1:0]),
		.in_front (s_tdata[TAG_W +: FRONT_W]),
		.in_last  (s_tlast),
		.out_free (out_free),
		.status   (status),
		.push     (push),
		.result   (result)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (push) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			out_res_q <= result;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(M_TDATA_W - TAG_W - POS_W){1'b0}}, out_res_q.position, out_res_q.tag};
	assign m_tlast  = out_res_q.last;
	assign m_tuser  = out_res_q.cycle;

	// a result is only loaded when the output register can take it
	a_push_free: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (!out_valid_q || m_tready))
		else $error("result pushed over a waiting word");

	// emission and loading never overlap
	a_push_no_load: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !s_tready)
		else $error("input taken while emitting");

	// the last node word starts a sort, so input closes
	a_sort_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && s_tlast) |=> !s_tready)
		else $error("input still open after last node");

	// cycle flag only rides on the final word of a run
	a_cycle_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> m_tlast)
		else $error("cycle flag on a word that is not last");
endmodule
